@@ sv/swrs_pkg.sv @@
// Shared types and constants for the stack with running sum unit.
// Holds command codes, result kinds, controller states and the command/status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swrs_pkg;

    localparam int SWRS_DEPTH = 64;
    localparam int DATA_W     = 64;
    // 200 * |sum| + count fits in DATA_W + 8 bits
    localparam int NUM_W      = DATA_W + 8;
    localparam int DIV_STEPS  = NUM_W / 2;
    localparam int DIV_CW     = $clog2(DIV_STEPS);

    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_SUM     = 3'd2;
    localparam logic [2:0] OP_AVERAGE = 3'd3;
    localparam logic [2:0] OP_PRINT   = 3'd4;
    localparam logic [2:0] OP_SQUARE  = 3'd5;

    localparam logic [1:0] KIND_ELEM  = 2'd0;
    localparam logic [1:0] KIND_SUM   = 2'd1;
    localparam logic [1:0] KIND_AVG   = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_SUB,
        S_AVG_MAG,
        S_AVG_SCALE,
        S_AVG_DIV,
        S_AVG_SAT,
        S_ONE_OUT,
        S_WALK_MUL,
        S_WALK_OUT
    } swrs_state_t;

    typedef enum logic [2:0] {
        SEL_SUM,
        SEL_AVG_ZERO,
        SEL_AVG,
        SEL_EMPTY,
        SEL_ELEM
    } swrs_sel_t;

    typedef struct packed {
        logic      push;
        logic      pop_rd;
        logic      pop_sub;
        logic      avg_mag;
        logic      avg_scale;
        logic      div_step;
        logic      avg_sat;
        logic      walk_start;
        logic      walk_mul;
        logic      walk_next;
        logic      square;
        logic      out_load;
        logic      out_last;
        swrs_sel_t sel;
    } swrs_cmd_t;

    typedef struct packed {
        logic empty;
        logic div_done;
        logic walk_last;
        logic out_free;
    } swrs_status_t;

endpackage

`default_nettype wire

@@ sv/swrs_dp.sv @@
// Datapath of the stack with running sum unit: stack memory, count, running sum,
// radix-4 averaging divider, split squarer and the result register.
// Depends on swrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swrs_dp #(
    parameter int DEPTH = swrs_pkg::SWRS_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire swrs_pkg::swrs_cmd_t                 cmd,
    output      swrs_pkg::swrs_status_t              status,
    input  wire logic signed [swrs_pkg::DATA_W-1:0]  push_value,
    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      logic [1:0]                          kind,
    output      logic signed [swrs_pkg::DATA_W-1:0]  result_value,
    output      logic                                last
);
    import swrs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = CW + 1;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] p_lo_reg, p_lo_next;
    logic [31:0]       p_mid_reg, p_mid_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DW-1:0]     den_reg, den_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DIV_CW-1:0] div_cnt_reg, div_cnt_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] avg_reg, avg_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              last_reg, last_next;

    logic              full;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DW:0]       step1, step2;
    logic [DATA_W-1:0] limit;
    logic [DATA_W-1:0] elem;

    // One restoring step: returns {quotient bit, new remainder}.
    function automatic logic [DW:0] div_bit(input logic [DW-1:0] rem,
                                            input logic          b,
                                            input logic [DW-1:0] den);
        logic [DW:0] sh;
        logic [DW:0] res;
        sh = {rem, b};
        if (sh >= {1'b0, den})
        begin
            res = {1'b1, DW'(sh - {1'b0, den})};
        end
        else
        begin
            res = {1'b0, sh[DW-1:0]};
        end
        return res;
    endfunction

    assign full             = (count_reg == CW'(DEPTH));
    assign status.empty     = (count_reg == '0);
    assign status.div_done  = (div_cnt_reg == DIV_CW'(DIV_STEPS - 1));
    assign status.walk_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign step1 = div_bit(rem_reg, num_reg[NUM_W-1], den_reg);
    assign step2 = div_bit(step1[DW-1:0], num_reg[NUM_W-2], den_reg);
    assign limit = neg_reg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    assign elem  = cmd.square ? (p_lo_reg + {p_mid_reg[30:0], 33'b0}) : x_reg;

    // Stack memory: one write port, one registered read port.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.pop_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = AW'(count_reg - CW'(1));
        end
        else if (cmd.walk_start)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        else if (cmd.walk_mul && !status.walk_last)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
        begin
            mem[count_reg[AW-1:0]] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        x_next         = x_reg;
        p_lo_next      = p_lo_reg;
        p_mid_next     = p_mid_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        neg_next       = neg_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        last_next      = last_reg;

        // drop a push on a full stack
        if (cmd.push && !full)
        begin
            count_next = count_reg + CW'(1);
            sum_next   = sum_reg + $unsigned(push_value);
        end
        if (cmd.pop_sub)
        begin
            count_next = count_reg - CW'(1);
            sum_next   = sum_reg - rd_data_reg;
        end

        if (cmd.avg_mag)
        begin
            neg_next = sum_reg[DATA_W-1];
            num_next = {8'b0, (sum_reg[DATA_W-1] ? (~sum_reg + DATA_W'(1)) : sum_reg)};
        end
        if (cmd.avg_scale)
        begin
            // 200 * |sum| + n, to be divided by 2n: rounds half away from zero
            num_next     = (num_reg << 7) + (num_reg << 6) + (num_reg << 3)
                           + NUM_W'(count_reg);
            den_next     = {count_reg, 1'b0};
            rem_next     = '0;
            div_cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            num_next     = {num_reg[NUM_W-3:0], step1[DW], step2[DW]};
            rem_next     = step2[DW-1:0];
            div_cnt_next = div_cnt_reg + DIV_CW'(1);
        end
        if (cmd.avg_sat)
        begin
            avg_next = (num_reg > NUM_W'(limit)) ? limit : num_reg[DATA_W-1:0];
        end

        if (cmd.walk_start)
        begin
            idx_next = '0;
        end
        if (cmd.walk_next)
        begin
            idx_next = idx_reg + AW'(1);
        end
        if (cmd.walk_mul)
        begin
            // low 64 bits of x*x from two 32x32 products
            x_next     = rd_data_reg;
            p_lo_next  = {32'b0, rd_data_reg[31:0]} * {32'b0, rd_data_reg[31:0]};
            p_mid_next = rd_data_reg[31:0] * rd_data_reg[63:32];
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            last_next      = cmd.out_last;
            case (cmd.sel)
                SEL_SUM:
                begin
                    kind_next  = KIND_SUM;
                    value_next = sum_reg;
                end
                SEL_AVG_ZERO:
                begin
                    kind_next  = KIND_AVG;
                    value_next = '0;
                end
                SEL_AVG:
                begin
                    kind_next  = KIND_AVG;
                    value_next = neg_reg ? (~avg_reg + DATA_W'(1)) : avg_reg;
                end
                SEL_EMPTY:
                begin
                    kind_next  = KIND_EMPTY;
                    value_next = '0;
                end
                SEL_ELEM:
                begin
                    kind_next  = KIND_ELEM;
                    value_next = elem;
                end
                default:
                begin
                    kind_next  = KIND_EMPTY;
                    value_next = '0;
                end
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        x_reg     <= x_next;
        p_lo_reg  <= p_lo_next;
        p_mid_reg <= p_mid_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        avg_reg   <= avg_next;
        kind_reg  <= kind_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign result_value = $signed(value_reg);
    assign last         = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("stack count beyond depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register loaded over a pending beat");

    a_full_push_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && full) |=> ($stable(sum_reg) && $stable(count_reg)))
        else $error("push on full stack changed state");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_sub |-> (count_reg != '0))
        else $error("pop committed on empty stack");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_mul |-> (CW'(idx_reg) < count_reg))
        else $error("walk index beyond stack top");

endmodule

`default_nettype wire

@@ sv/swrs_ctrl.sv @@
// Controller of the stack with running sum unit: one command at a time,
// sequencing pop, average, single results and the bottom-to-top walk.
// Depends on swrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swrs_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire logic [2:0]             op,
    input  wire swrs_pkg::swrs_status_t status,
    output      swrs_pkg::swrs_cmd_t    cmd
);
    import swrs_pkg::*;

    swrs_state_t state_reg, state_next;
    logic [2:0]  op_reg, op_next;

    assign op_next = (state_reg == S_IDLE && in_valid) ? op : op_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        OP_POP:     state_next = status.empty ? S_IDLE : S_POP_SUB;
                        OP_SUM:     state_next = S_ONE_OUT;
                        OP_AVERAGE: state_next = status.empty ? S_ONE_OUT : S_AVG_MAG;
                        OP_PRINT,
                        OP_SQUARE:  state_next = status.empty ? S_ONE_OUT : S_WALK_MUL;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_POP_SUB:   state_next = S_IDLE;
            S_AVG_MAG:   state_next = S_AVG_SCALE;
            S_AVG_SCALE: state_next = S_AVG_DIV;
            S_AVG_DIV:   state_next = status.div_done ? S_AVG_SAT : S_AVG_DIV;
            S_AVG_SAT:   state_next = S_ONE_OUT;
            S_ONE_OUT:   state_next = status.out_free ? S_IDLE : S_ONE_OUT;
            S_WALK_MUL:  state_next = S_WALK_OUT;
            S_WALK_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = status.walk_last ? S_IDLE : S_WALK_MUL;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = SEL_EMPTY;
        cmd.square = (op_reg == OP_SQUARE);
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (op)
                        OP_PUSH:    cmd.push = 1'b1;
                        OP_POP:     cmd.pop_rd = !status.empty;
                        OP_PRINT,
                        OP_SQUARE:  cmd.walk_start = !status.empty;
                        default:    cmd.push = 1'b0;
                    endcase
                end
            end
            S_POP_SUB:   cmd.pop_sub = 1'b1;
            S_AVG_MAG:   cmd.avg_mag = 1'b1;
            S_AVG_SCALE: cmd.avg_scale = 1'b1;
            S_AVG_DIV:   cmd.div_step = 1'b1;
            S_AVG_SAT:   cmd.avg_sat = 1'b1;
            S_ONE_OUT:
            begin
                cmd.out_load = status.out_free;
                cmd.out_last = 1'b1;
                if (op_reg == OP_SUM)
                begin
                    cmd.sel = SEL_SUM;
                end
                else if (op_reg == OP_AVERAGE)
                begin
                    cmd.sel = status.empty ? SEL_AVG_ZERO : SEL_AVG;
                end
                else
                begin
                    cmd.sel = SEL_EMPTY;
                end
            end
            S_WALK_MUL:  cmd.walk_mul = 1'b1;
            S_WALK_OUT:
            begin
                cmd.sel       = SEL_ELEM;
                cmd.out_load  = status.out_free;
                cmd.out_last  = status.walk_last;
                cmd.walk_next = status.out_free && !status.walk_last;
            end
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    a_single_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ONE_OUT && cmd.out_load) |-> cmd.out_last)
        else $error("single result without last");

    a_walk_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_OUT && cmd.out_load && cmd.out_last) |=> (state_reg == S_IDLE))
        else $error("walk did not finish on last beat");

    a_avg_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AVG_SAT) |-> ($past(state_reg) == S_AVG_DIV && $past(status.div_done)))
        else $error("average left the divider early");

endmodule

`default_nettype wire

@@ sv/stack_with_running_sum_unit.sv @@
// Top level of the stack with running sum unit.
// Instantiates the controller (swrs_ctrl) and the datapath (swrs_dp); depends on swrs_pkg.
//
// A bounded stack of signed 64-bit values with a running sum, one command per input
// beat. Push adds the value on top and to the sum (dropped silently when full); pop
// removes the top and subtracts it (ignored when empty); both give no result beat.
// Sum returns the sum modulo 2^64. Average returns round(100 * sum / count), half
// away from zero, saturated to 64 bits, or 0 on an empty stack. Print and square
// return one beat per element from bottom to top, last marked, or one empty-marker
// beat on an empty stack. Commands are taken one at a time; input ready is high only
// while the controller is idle, but a finished result can still sit in the output
// register while the next command is taken. Average passes through the magnitude,
// scale, two-bit-per-cycle divider and saturation states; print and square step each
// element through a read/multiply state and an output state, since each element goes
// through the single memory read port. A stalled output holds the controller in its output state.
// The stack store holds no reset; only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_running_sum_unit #(
    parameter int STACK_DEPTH = swrs_pkg::SWRS_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output      logic                                in_ready,
    input  wire logic [2:0]                          op,
    input  wire logic signed [swrs_pkg::DATA_W-1:0]  push_value,
    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      logic [1:0]                          kind,
    output      logic signed [swrs_pkg::DATA_W-1:0]  result_value,
    output      logic                                last
);
    import swrs_pkg::*;

    // command and status bundles between controller and datapath
    swrs_cmd_t    cmd;
    swrs_status_t status;

    // sequence one command at a time
    swrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    // hold the stack, sum, divider, squarer and the output beat
    swrs_dp #(
        .DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .result_value (result_value),
        .last         (last)
    );

endmodule

`default_nettype wire

@@ dv/stack_with_running_sum_unit_test.sv @@
// Self-checking testbench for stack_with_running_sum_unit: directed corner cases, a full-stack
// backpressure run and biased random traffic, all scored against an in-bench stack predictor.
// Depends on swrs_pkg and the unit itself.
`timescale 1ns / 1ps

module stack_with_running_sum_unit_test;

    import swrs_pkg::*;

    // Command codes the unit has no use for; it must swallow them silently.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam int RANDOM_COMMANDS = 270;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_LIMIT     = 50000;
    localparam int TAIL_CYCLES     = 200;
    localparam int MAX_REPORTS     = 200;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
        logic        last;
    } result_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_REPORT
    } traffic_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  op;
    logic [63:0] push_value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [63:0] result_value;
    logic        last;

    stack_with_running_sum_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .result_value (result_value),
        .last         (last)
    );

    // Predictor state: a shadow of the stack, its fill level and the wrapped sum.
    logic [63:0] stack_image [SWRS_DEPTH];
    int          stack_fill;
    logic [63:0] running_total;
    result_t     pending_results [$];

    // Run bookkeeping.
    int n_errors;
    int n_reports;
    int n_commands;
    int n_beats;
    int n_dropped;
    int n_saturated;

    // Shared between the stimulus and the receiver.
    bit smooth_mode;   // set: no idle cycles on either side
    bit hold_request;  // set: receiver holds off for HOLD_CYCLES
    bit offering;      // mirror of in_valid as last driven by the sender

    // ------------------------------------------------------------------
    // Clock, and a hard stop in case the unit hangs.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Timeout at %0t with %0d result beats still expected", $time,
                 pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Idle-length picker shared by sender and receiver: mostly none,
    // some short, a few long. Smooth mode suppresses idling altogether.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (smooth_mode || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(15, 40);
    endfunction

    // ------------------------------------------------------------------
    // Average times 100 of a wrapped sum over n entries, rounded half away
    // from zero and clamped to the signed 64-bit range. Work on the
    // magnitude, then restore the sign.
    // ------------------------------------------------------------------
    function automatic logic [63:0] average_x100(logic [63:0] total, int unsigned n);
        logic        neg;
        logic [63:0] nn;
        logic [63:0] mag;
        logic [63:0] cap;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] res;
        nn   = 64'(n);
        neg  = total[63];
        mag  = neg ? -total : total;
        cap  = neg ? VAL_MIN : VAL_MAX;
        quo  = mag / nn;
        rem  = mag % nn;
        frac = (64'd200 * rem + nn) / (64'd2 * nn);
        if (quo > cap / 64'd100)
            res = cap;
        else
        begin
            res = quo * 64'd100;
            if (frac > cap - res)
                res = cap;
            else
                res = res + frac;
        end
        if (res == cap)
            n_saturated++;
        return neg ? -res : res;
    endfunction

    // Append one expected beat at the tail of the queue.
    function automatic void add_expected(input result_t beat);
        pending_results.insert(pending_results.size(), beat);
    endfunction

    // ------------------------------------------------------------------
    // Apply one accepted command to the shadow stack and queue the result
    // beats it should produce.
    // ------------------------------------------------------------------
    task automatic predict_command(input logic [2:0] code, input logic [63:0] value);
        result_t     beat;
        logic [63:0] entry;
        case (code)
            OP_PUSH:
            begin
                if (stack_fill < SWRS_DEPTH)
                begin
                    stack_image[stack_fill] = value;
                    stack_fill++;
                    running_total = running_total + value;
                end
                else
                    n_dropped++;
            end
            OP_POP:
            begin
                if (stack_fill > 0)
                begin
                    stack_fill--;
                    running_total = running_total - stack_image[stack_fill];
                end
            end
            OP_SUM:
            begin
                beat = '{kind: KIND_SUM, value: running_total, last: 1'b1};
                add_expected(beat);
            end
            OP_AVERAGE:
            begin
                beat = '{kind: KIND_AVG, value: 64'd0, last: 1'b1};
                if (stack_fill > 0)
                    beat.value = average_x100(running_total, stack_fill);
                add_expected(beat);
            end
            OP_PRINT, OP_SQUARE:
            begin
                if (stack_fill == 0)
                begin
                    beat = '{kind: KIND_EMPTY, value: 64'd0, last: 1'b1};
                    add_expected(beat);
                end
                // Walk bottom to top; squares wrap to 64 bits.
                for (int i = 0; i < stack_fill; i++)
                begin
                    entry = stack_image[i];
                    beat.kind  = KIND_ELEM;
                    beat.value = (code == OP_SQUARE) ? entry * entry : entry;
                    beat.last  = (i == stack_fill - 1);
                    add_expected(beat);
                end
            end
            default:
            begin
                // spare codes: no result, no state change
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender: idle for a random gap, then offer one command and hold it
    // until the unit takes it. Valid is lowered only when a gap follows,
    // so back-to-back beats keep it high without a glitch.
    // ------------------------------------------------------------------
    task automatic send_command(input logic [2:0] code, input logic [63:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            if (offering)
                in_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= code;
        push_value <= value;
        offering    = 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        predict_command(code, value);
        n_commands++;
    endtask

    // Drop valid and wait for every expected beat to come back.
    task automatic settle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering  = 1'b0;
            @(posedge clk);
        end
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls on out_ready, plus one long hold-off on
    // request, counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int idle_left;
        idle_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready   <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready   <= 1'b1;
            end
            else if (idle_left > 0)
            begin
                out_ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                idle_left  = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: compare every accepted result beat with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_beats++;
            if (pending_results.size() == 0)
            begin
                n_errors++;
                if (n_reports++ < MAX_REPORTS)
                    $display("%0t: unexpected beat kind %0d value %0d last %0b", $time,
                             kind, $signed(result_value), last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                begin
                    n_errors++;
                    if (n_reports++ < MAX_REPORTS)
                        $display("%0t: kind expected %0d actual %0d", $time,
                                 want.kind, kind);
                end
                if (result_value !== want.value)
                begin
                    n_errors++;
                    if (n_reports++ < MAX_REPORTS)
                        $display("%0t: result_value expected %0d actual %0d", $time,
                                 $signed(want.value), $signed(result_value));
                end
                if (last !== want.last)
                begin
                    n_errors++;
                    if (n_reports++ < MAX_REPORTS)
                        $display("%0t: last expected %0b actual %0b", $time,
                                 want.last, last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Random content helpers.
    // ------------------------------------------------------------------
    function automatic logic [63:0] pick_value();
        int r;
        int s;
        r = $urandom_range(0, 9);
        if (r < 4)
            return {$urandom, $urandom};
        if (r < 7)
        begin
            s = int'($urandom_range(0, 2000)) - 1000;
            return {{32{s[31]}}, s};
        end
        if (r == 7)
        begin
            case ($urandom_range(0, 4))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return 64'd0;
                3:       return '1;
                default: return 64'd1;
            endcase
        end
        // Large magnitudes push the sum toward saturation of the average.
        if (r == 8)
            return {1'b0, 31'($urandom), $urandom};
        return {1'b1, 31'($urandom), $urandom};
    endfunction

    function automatic logic [2:0] pick_op(traffic_mode_t mode);
        int r;
        int push_pct;
        int pop_pct;
        r = $urandom_range(0, 99);
        case (mode)
            MIX_FILL:     begin push_pct = 75; pop_pct = 8;  end
            MIX_DRAIN:    begin push_pct = 15; pop_pct = 60; end
            MIX_BALANCED: begin push_pct = 40; pop_pct = 20; end
            default:      begin push_pct = 20; pop_pct = 15; end
        endcase
        if (r < 3)
            return (r == 0) ? OP_SPARE_6 : OP_SPARE_7;
        if (r < push_pct)
            return OP_PUSH;
        if (r < push_pct + pop_pct)
            return OP_POP;
        case (r % 4)
            0:       return OP_SUM;
            1:       return OP_AVERAGE;
            2:       return OP_PRINT;
            default: return OP_SQUARE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Everything on an empty stack: ignored pop, zero sum and average,
    // empty marker for print and square, spare codes dropped.
    task automatic test_empty_stack();
        send_command(OP_POP,     VAL_MAX);
        send_command(OP_SUM,     64'd0);
        send_command(OP_AVERAGE, 64'd0);
        send_command(OP_PRINT,   64'd0);
        send_command(OP_SQUARE,  '1);
        send_command(OP_SPARE_6, VAL_MIN);
        send_command(OP_SPARE_7, '1);
        send_command(OP_SUM,     64'd0);
        settle();
    endtask

    // Extreme values, saturation at the negative limit, wrapped squares, and rounding
    // of exact halves away from zero in both signs.
    task automatic test_extremes_and_rounding();
        send_command(OP_PUSH,    VAL_MIN);
        send_command(OP_AVERAGE, 64'd0);      // clamps to the negative limit
        send_command(OP_PUSH,    VAL_MAX);
        send_command(OP_SUM,     64'd0);      // wraps to -1
        send_command(OP_AVERAGE, 64'd0);      // -0.5 over two entries
        send_command(OP_SQUARE,  64'd0);
        send_command(OP_POP,     64'd0);
        send_command(OP_AVERAGE, 64'd0);      // clamps to the negative limit again
        send_command(OP_POP,     64'd0);
        // Eight entries summing to 1: 12.5 rounds to 13.
        send_command(OP_PUSH, 64'd3);
        send_command(OP_PUSH, -64'sd2);
        send_command(OP_PUSH, 64'd7);
        send_command(OP_PUSH, -64'sd7);
        repeat (4) send_command(OP_PUSH, 64'd0);
        send_command(OP_AVERAGE, 64'd0);
        send_command(OP_POP,     64'd0);
        // Eight entries summing to -1: -12.5 rounds to -13.
        send_command(OP_PUSH,    -64'sd2);
        send_command(OP_AVERAGE, 64'd0);
        send_command(OP_PRINT,   64'd0);
        settle();
    endtask

    // Fill the stack while the receiver is held off, so the output backs
    // up and input ready drops; then overflow it and report everything.
    task automatic test_full_stack_backpressure();
        hold_request = 1'b1;
        while (stack_fill < SWRS_DEPTH)
            send_command(OP_PUSH, pick_value());
        send_command(OP_PRINT,   64'd0);
        send_command(OP_PUSH,    VAL_MAX);    // dropped: stack full
        send_command(OP_PUSH,    VAL_MIN);    // dropped
        send_command(OP_SUM,     64'd0);
        send_command(OP_AVERAGE, 64'd0);
        send_command(OP_SQUARE,  64'd0);
        send_command(OP_PRINT,   64'd0);
        settle();
    endtask

    // Segments of biased traffic so the fill level wanders over the whole
    // range; some segments run with no idling on either side.
    task automatic test_random_traffic();
        int            sent;
        int            seg_len;
        traffic_mode_t mode;
        sent = 0;
        while (sent < RANDOM_COMMANDS)
        begin
            mode        = traffic_mode_t'($urandom_range(0, 3));
            seg_len     = $urandom_range(15, 40);
            smooth_mode = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < seg_len && sent < RANDOM_COMMANDS; k++)
            begin
                send_command(pick_op(mode), pick_value());
                sent++;
            end
        end
        smooth_mode = 1'b0;
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_PUSH;
        push_value    = '0;
        stack_fill    = 0;
        running_total = '0;
        n_errors      = 0;
        n_reports     = 0;
        n_commands    = 0;
        n_beats       = 0;
        n_dropped     = 0;
        n_saturated   = 0;
        smooth_mode   = 1'b0;
        hold_request  = 1'b0;
        offering      = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_extremes_and_rounding();
        test_full_stack_backpressure();
        test_random_traffic();

        // Drop valid, wait out the remaining beats, then watch for strays.
        if (offering)
        begin
            in_valid <= 1'b0;
            offering  = 1'b0;
        end
        for (int w = 0; pending_results.size() != 0 && w < DRAIN_LIMIT; w++)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            n_errors++;
            $display("%0t: %0d result beats never arrived", $time, pending_results.size());
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d commands, checked %0d result beats; %0d pushes hit a full stack,",
                 n_commands, n_beats, n_dropped);
        $display("%0d averages clamped, %0d mismatches", n_saturated, n_errors);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/swrs_pkg.sv
sv/swrs_dp.sv
sv/swrs_ctrl.sv
sv/stack_with_running_sum_unit.sv
dv/stack_with_running_sum_unit_test.sv
